// ===== rtl/cgc_pkg.sv =====
package cgc_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_W = 34;
   localparam int PROD_W = 2 * MUL_W;

   // knee divider widths
   localparam int DIV_NUM_W = 28;
   localparam int DIV_DEN_W = 14;

   // 2^(2^-i) factors in Q30, entry 0 is 2.0
   localparam int ROOT_N = 21;

   typedef enum logic [2:0] {
      CSR_THRESHOLD     = 3'd0,
      CSR_KNEE          = 3'd1,
      CSR_SLOPE         = 3'd2,
      CSR_ALPHA_ATTACK  = 3'd3,
      CSR_ALPHA_RELEASE = 3'd4,
      CSR_MAKEUP        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0] level;
      logic        block_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] reduction_db;
      logic [15:0]        gain_linear;
      logic signed [15:0] peak_level_db;
      logic signed [15:0] max_reduction_db;
   } rsp_payload_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef logic [31:0] root_table_type [ROOT_N];

   // floor square root, one result bit per step
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem = x;
      res = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // each factor is the floor square root of the one before
   function automatic root_table_type root_table();
      root_table_type t;
      logic [63:0]    r;
      r = 64'h8000_0000;
      for (int i = 0; i < ROOT_N; i++) begin
         t[i] = r[31:0];
         r = isqrt64(r << 30);
      end
      return t;
   endfunction

endpackage

// ===== rtl/cgc_stream_if.sv =====
interface cgc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/cgc_mul.sv =====
module cgc_mul (
   input  logic                                clock,
   input  logic signed [cgc_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [cgc_pkg::MUL_W-1:0]    mul_b,
   output logic signed [cgc_pkg::PROD_W-1:0]   prod
);

   logic signed [cgc_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/cgc_div.sv =====
module cgc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cgc_pkg::div_req_type  div_req,
   output cgc_pkg::div_rsp_type  div_rsp
);

   localparam int NUM_W = cgc_pkg::DIV_NUM_W;
   localparam int DEN_W = cgc_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      quo_in = quo_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in = div_req.dividend;
         den_in = div_req.divisor;
         rem_in = '0;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/compressor_gain_computer.sv =====
// sequence: a nonzero level runs the log loop, a zero level skips it and goes straight to
//   the curve; the knee adds the quadratic and the knee divider, the linear gain adds the
//   exp factor loop on the shared multiplier unless the gain is muted or clipped, and the
//   slope above the knee adds a multiply and round; the response is held until taken
// throughput: one request in flight at a time, the next accepted only after the response is taken
// reset: synchronous, control and programmed registers to their reset values, smoother and deepest reduction 0 dB
module compressor_gain_computer (
   input  logic              clock,
   input  logic              reset,
   cgc_stream_if.sink        req_chan,
   cgc_stream_if.source      rsp_chan,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [16:0]       csr_data
);

   localparam int MUL_W = cgc_pkg::MUL_W;
   localparam int PROD_W = cgc_pkg::PROD_W;

   localparam logic signed [15:0] DB_FLOOR = -16'sd25600;
   localparam logic [18:0] LOG2_TO_DB = 19'd394566;
   // 44586164 split as 680 * 2^16 + 21684
   localparam logic [14:0] DB_TO_LOG2_LO = 15'd21684;
   localparam logic [9:0] DB_TO_LOG2_HI = 10'd680;

   localparam logic signed [15:0] THRESHOLD_RESET = -16'sd2560;
   localparam logic [13:0] KNEE_RESET = 14'd1536;
   localparam logic signed [15:0] SLOPE_RESET = -16'sd16384;
   localparam logic [16:0] ATTACK_RESET = 17'd6554;
   localparam logic [16:0] RELEASE_RESET = 17'd655;
   localparam logic signed [13:0] MAKEUP_RESET = 14'sd0;

   localparam cgc_pkg::root_table_type ROOT_TABLE = cgc_pkg::root_table();

   typedef enum logic [24:0] {
      S_IDLE    = 25'h0000001,
      S_SQ_MUL  = 25'h0000002,
      S_SQ_ACC  = 25'h0000004,
      S_DB_MUL  = 25'h0000008,
      S_DB_RND  = 25'h0000010,
      S_CURVE   = 25'h0000020,
      S_KQ_MUL1 = 25'h0000040,
      S_KQ_MUL2 = 25'h0000080,
      S_KQ_DIV  = 25'h0000100,
      S_KQ_WAIT = 25'h0000200,
      S_HI_MUL  = 25'h0000400,
      S_HI_RND  = 25'h0000800,
      S_SM_DIFF = 25'h0001000,
      S_SM_MULL = 25'h0002000,
      S_SM_MULH = 25'h0004000,
      S_SM_ACC  = 25'h0008000,
      S_RED     = 25'h0010000,
      S_EX_D    = 25'h0020000,
      S_EX_MUL1 = 25'h0040000,
      S_EX_MUL2 = 25'h0080000,
      S_EX_SUM  = 25'h0100000,
      S_EX_MUL  = 25'h0200000,
      S_EX_UPD  = 25'h0400000,
      S_EX_RND  = 25'h0800000,
      S_OUT     = 25'h1000000
   } state_type;

   // control and programmed registers
   state_type          state_ff, state_in;
   logic signed [15:0] thr_ff, thr_in;
   logic [13:0]        knee_ff, knee_in;
   logic signed [15:0] slope_ff, slope_in;
   logic [16:0]        att_ff, att_in;
   logic [16:0]        rel_ff, rel_in;
   logic signed [13:0] makeup_ff, makeup_in;
   logic signed [31:0] smooth_ff, smooth_in;
   logic signed [15:0] peak_ff, peak_in;
   logic signed [15:0] deep_ff, deep_in;
   logic [4:0]         cnt_ff, cnt_in;

   // datapath registers
   logic [30:0]        m_ff, m_in;
   logic signed [20:0] l2_ff, l2_in;
   logic signed [15:0] db_ff, db_in;
   logic signed [17:0] over_ff, over_in;
   logic [14:0]        u_ff, u_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] target_ff, target_in;
   logic signed [32:0] diff_ff, diff_in;
   logic [16:0]        alpha_ff, alpha_in;
   logic [17:0]        lo_ff, lo_in;
   logic signed [15:0] red_ff, red_in;
   logic signed [16:0] d_ff, d_in;
   logic signed [16:0] lo2_ff, lo2_in;
   logic [19:0]        f_ff, f_in;
   logic [5:0]         shift_ff, shift_in;
   logic [31:0]        mant_ff, mant_in;
   logic [15:0]        gain_ff, gain_in;

   // shared multiplier and knee divider
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   cgc_pkg::div_req_type     div_req;
   cgc_pkg::div_rsp_type     div_rsp;

   // combinational helpers
   logic               req_acc;
   logic [3:0]         lead;
   logic [31:0]        sq;
   logic signed [40:0] db_sum;
   logic signed [15:0] db_round;
   logic signed [17:0] over_c;
   logic signed [18:0] two_c, knee_c;
   logic signed [46:0] kq, kq_mag, kq_num;
   logic signed [35:0] hi_sum;
   logic signed [20:0] hi_round;
   logic signed [32:0] diff_c;
   logic [33:0]        lo_sum;
   logic signed [35:0] st_sum;
   logic signed [32:0] red_sum;
   logic signed [16:0] red_round;
   logic signed [15:0] red_c;
   logic signed [16:0] d_c;
   logic signed [32:0] lo2_sum;
   logic signed [26:0] e_c;
   logic signed [6:0]  ip;
   logic signed [6:0]  shift_c;
   logic [36:0]        rsum, g_c;
   logic [4:0]         fbit_idx;

   assign req_acc = req_chan.valid && req_chan.ready;

   // msb position of the level
   always_comb begin
      lead = '0;
      for (int k = 0; k < 16; k++) begin
         if (req_chan.payload.level[k]) begin
            lead = 4'(k);
         end
      end
   end

   // log2: squared mantissa in Q2.30, renormalized to Q1.30
   assign sq = mul_prod[61:30];
   // log2 Q16 to dB Q8.8, round half up
   assign db_sum = mul_prod[40:0] + 41'sd8388608;
   assign db_round = db_sum[39:24];

   // overshoot over threshold and knee bounds
   assign over_c = {{2{db_ff[15]}}, db_ff} - {{2{thr_ff[15]}}, thr_ff};
   assign two_c = {over_c, 1'b0};
   assign knee_c = {5'd0, knee_ff};

   // knee quadratic: magnitude plus half the divisor, then divide by knee * 2^18
   assign kq = mul_prod[46:0];
   assign kq_mag = kq[46] ? -kq : kq;
   assign kq_num = kq_mag + {16'd0, knee_ff, 17'd0};

   // above the knee: slope * overshoot / 2^15, round half up
   assign hi_sum = mul_prod[35:0] + 36'sd16384;
   assign hi_round = hi_sum[35:15];

   // smoother, alpha * diff split into the low 16-bit and high 17-bit parts of diff
   assign diff_c = {target_ff[15], target_ff, 16'd0} - {smooth_ff[31], smooth_ff};
   assign lo_sum = {1'b0, mul_prod[32:0]} + 34'd32768;
   assign st_sum = {{4{smooth_ff[31]}}, smooth_ff} + {{2{mul_prod[33]}}, mul_prod[33:0]}
                   + {18'd0, lo_ff};

   // reduction in Q8.8 from the Q8.24 state
   assign red_sum = {smooth_ff[31], smooth_ff} + 33'sd32768;
   assign red_round = red_sum[32:16];
   always_comb begin
      if (red_round > 17'sd32767) begin
         red_c = 16'sh7fff;
      end else if (red_round < -17'sd32768) begin
         red_c = 16'sh8000;
      end else begin
         red_c = red_round[15:0];
      end
   end

   // dB to log2 Q20
   assign d_c = {red_ff[15], red_ff} + {{3{makeup_ff[13]}}, makeup_ff};
   assign lo2_sum = mul_prod[32:0] + 33'sd32768;
   assign e_c = mul_prod[26:0] + {{10{lo2_ff[16]}}, lo2_ff};
   assign ip = e_c[26:20];
   assign shift_c = 7'sd18 - ip;
   assign fbit_idx = 5'd20 - cnt_ff;

   // final rounding to Q4.12
   assign rsum = {5'd0, mant_ff} + (37'd1 << (shift_ff - 6'd1));
   assign g_c = rsum >> shift_ff;

   always_comb begin
      state_in = state_ff;
      thr_in = thr_ff;
      knee_in = knee_ff;
      slope_in = slope_ff;
      att_in = att_ff;
      rel_in = rel_ff;
      makeup_in = makeup_ff;
      smooth_in = smooth_ff;
      peak_in = peak_ff;
      deep_in = deep_ff;
      cnt_in = cnt_ff;
      m_in = m_ff;
      l2_in = l2_ff;
      db_in = db_ff;
      over_in = over_ff;
      u_in = u_ff;
      neg_in = neg_ff;
      target_in = target_ff;
      diff_in = diff_ff;
      alpha_in = alpha_ff;
      lo_in = lo_ff;
      red_in = red_ff;
      d_in = d_ff;
      lo2_in = lo2_ff;
      f_in = f_ff;
      shift_in = shift_ff;
      mant_in = mant_ff;
      gain_in = gain_ff;
      mul_a = '0;
      mul_b = '0;
      div_req.start = 1'b0;
      div_req.dividend = kq_num[45:18];
      div_req.divisor = knee_ff;

      // the user must make register writes only while idle, the block itself does not enforce it
      if (csr_write) begin
         unique case (csr_index)
            cgc_pkg::CSR_THRESHOLD:     thr_in = csr_data[15:0];
            cgc_pkg::CSR_KNEE:          knee_in = csr_data[13:0];
            cgc_pkg::CSR_SLOPE:         slope_in = csr_data[15:0];
            cgc_pkg::CSR_ALPHA_ATTACK:  att_in = csr_data;
            cgc_pkg::CSR_ALPHA_RELEASE: rel_in = csr_data;
            cgc_pkg::CSR_MAKEUP:        makeup_in = csr_data[13:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_chan.payload.block_start) begin
                  peak_in = DB_FLOOR;
                  deep_in = '0;
               end
               m_in = 31'({req_chan.payload.level, 15'd0} << (4'd15 - lead));
               l2_in = {5'({1'b0, lead} - 5'd15), 16'd0};
               cnt_in = 5'd15;
               if (req_chan.payload.level == '0) begin
                  // zero level reads as the floor, no log needed
                  db_in = DB_FLOOR;
                  state_in = S_CURVE;
               end else begin
                  state_in = S_SQ_MUL;
               end
            end
         end
         S_SQ_MUL: begin
            mul_a = {3'd0, m_ff};
            mul_b = {3'd0, m_ff};
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            if (sq[31]) begin
               m_in = sq[31:1];
               l2_in[cnt_ff[3:0]] = 1'b1;
            end else begin
               m_in = sq[30:0];
            end
            if (cnt_ff == '0) begin
               state_in = S_DB_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               state_in = S_SQ_MUL;
            end
         end
         S_DB_MUL: begin
            mul_a = {{13{l2_ff[20]}}, l2_ff};
            mul_b = {15'd0, LOG2_TO_DB};
            state_in = S_DB_RND;
         end
         S_DB_RND: begin
            db_in = (db_round < DB_FLOOR) ? DB_FLOOR : db_round;
            if (db_round > peak_ff) begin
               peak_in = db_round;
            end
            state_in = S_CURVE;
         end
         S_CURVE: begin
            over_in = over_c;
            u_in = 15'(two_c + knee_c);
            if (two_c <= -knee_c) begin
               target_in = '0;
               state_in = S_SM_DIFF;
            end else if (two_c <= knee_c) begin
               state_in = S_KQ_MUL1;
            end else begin
               state_in = S_HI_MUL;
            end
         end
         S_KQ_MUL1: begin
            mul_a = {19'd0, u_ff};
            mul_b = {19'd0, u_ff};
            state_in = S_KQ_MUL2;
         end
         S_KQ_MUL2: begin
            mul_a = {{18{slope_ff[15]}}, slope_ff};
            mul_b = {3'd0, mul_prod[30:0]};
            state_in = S_KQ_DIV;
         end
         S_KQ_DIV: begin
            neg_in = kq[46];
            div_req.start = 1'b1;
            state_in = S_KQ_WAIT;
         end
         S_KQ_WAIT: begin
            if (div_rsp.done) begin
               target_in = neg_ff ? -div_rsp.quotient[15:0] : div_rsp.quotient[15:0];
               state_in = S_SM_DIFF;
            end
         end
         S_HI_MUL: begin
            mul_a = {{18{slope_ff[15]}}, slope_ff};
            mul_b = {{16{over_ff[17]}}, over_ff};
            state_in = S_HI_RND;
         end
         S_HI_RND: begin
            if (hi_round > 21'sd32767) begin
               target_in = 16'sh7fff;
            end else if (hi_round < -21'sd32768) begin
               target_in = 16'sh8000;
            end else begin
               target_in = hi_round[15:0];
            end
            state_in = S_SM_DIFF;
         end
         S_SM_DIFF: begin
            diff_in = diff_c;
            // attack when the reduction deepens
            alpha_in = diff_c[32] ? att_ff : rel_ff;
            state_in = S_SM_MULL;
         end
         S_SM_MULL: begin
            mul_a = {17'd0, alpha_ff};
            mul_b = {18'd0, diff_ff[15:0]};
            state_in = S_SM_MULH;
         end
         S_SM_MULH: begin
            lo_in = lo_sum[33:16];
            mul_a = {17'd0, alpha_ff};
            mul_b = {{17{diff_ff[32]}}, diff_ff[32:16]};
            state_in = S_SM_ACC;
         end
         S_SM_ACC: begin
            if (st_sum > 36'sd2147483647) begin
               smooth_in = 32'sh7fff_ffff;
            end else if (st_sum < -36'sd2147483648) begin
               smooth_in = 32'sh8000_0000;
            end else begin
               smooth_in = st_sum[31:0];
            end
            state_in = S_RED;
         end
         S_RED: begin
            red_in = red_c;
            if (red_c < deep_ff) begin
               deep_in = red_c;
            end
            state_in = S_EX_D;
         end
         S_EX_D: begin
            d_in = d_c;
            if (d_c <= -17'sd25600) begin
               gain_in = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_EX_MUL1;
            end
         end
         S_EX_MUL1: begin
            mul_a = {{17{d_ff[16]}}, d_ff};
            mul_b = {19'd0, DB_TO_LOG2_LO};
            state_in = S_EX_MUL2;
         end
         S_EX_MUL2: begin
            lo2_in = lo2_sum[32:16];
            mul_a = {{17{d_ff[16]}}, d_ff};
            mul_b = {24'd0, DB_TO_LOG2_HI};
            state_in = S_EX_SUM;
         end
         S_EX_SUM: begin
            f_in = e_c[19:0];
            shift_in = shift_c[5:0];
            mant_in = 32'h4000_0000;
            cnt_in = 5'd1;
            if (ip >= 7'sd4) begin
               // gain at or above 16.0
               gain_in = 16'hffff;
               state_in = S_OUT;
            end else begin
               state_in = S_EX_MUL;
            end
         end
         S_EX_MUL: begin
            mul_a = {2'd0, mant_ff};
            mul_b = {2'd0, ROOT_TABLE[cnt_ff]};
            state_in = S_EX_UPD;
         end
         S_EX_UPD: begin
            if (f_ff[fbit_idx]) begin
               mant_in = mul_prod[61:30];
            end
            if (cnt_ff == 5'd20) begin
               state_in = S_EX_RND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = S_EX_MUL;
            end
         end
         S_EX_RND: begin
            gain_in = (|g_c[36:16]) ? 16'hffff : g_c[15:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   cgc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (mul_prod)
   );

   cgc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff <= THRESHOLD_RESET;
         knee_ff <= KNEE_RESET;
         slope_ff <= SLOPE_RESET;
         att_ff <= ATTACK_RESET;
         rel_ff <= RELEASE_RESET;
         makeup_ff <= MAKEUP_RESET;
         smooth_ff <= '0;
         peak_ff <= DB_FLOOR;
         deep_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         thr_ff <= thr_in;
         knee_ff <= knee_in;
         slope_ff <= slope_in;
         att_ff <= att_in;
         rel_ff <= rel_in;
         makeup_ff <= makeup_in;
         smooth_ff <= smooth_in;
         peak_ff <= peak_in;
         deep_ff <= deep_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      l2_ff <= l2_in;
      db_ff <= db_in;
      over_ff <= over_in;
      u_ff <= u_in;
      neg_ff <= neg_in;
      target_ff <= target_in;
      diff_ff <= diff_in;
      alpha_ff <= alpha_in;
      lo_ff <= lo_in;
      red_ff <= red_in;
      d_ff <= d_in;
      lo2_ff <= lo2_in;
      f_ff <= f_in;
      shift_ff <= shift_in;
      mant_ff <= mant_in;
      gain_ff <= gain_in;
   end

   // request side is open only when idle, response held until taken
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = (state_ff == S_OUT);
   assign rsp_chan.payload.reduction_db = red_ff;
   assign rsp_chan.payload.gain_linear = gain_ff;
   assign rsp_chan.payload.peak_level_db = peak_ff;
   assign rsp_chan.payload.max_reduction_db = deep_ff;

   // a request starts either the log loop or, for a zero level, the curve directly
   a_req_start: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_SQ_MUL || state_ff == S_CURVE))
      else $error("request did not start processing");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_KQ_WAIT))
      else $error("divider done outside knee wait");

   // deepest reduction never above the reduction just reported
   a_deep_le_red: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (deep_ff <= red_ff))
      else $error("deepest reduction above current reduction");

   // output shift stays within the range the exponent allows
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EX_RND) |-> (shift_ff >= 6'd15 && shift_ff <= 6'd35))
      else $error("gain shift out of range");

endmodule
